FILE: hw/rtl/hss_pkg.sv
`timescale 1ns / 1ps
package hss_pkg;
  localparam int MaxNodes = 64;
  localparam int IdW = 6;
  localparam int CntW = 7;
  localparam int GridBits = 16;
  localparam int KeyW = 2 * GridBits;
  localparam int EntW = KeyW + IdW;
  localparam int QuoW = GridBits;
  localparam int PosW = $clog2(GridBits);
  localparam logic [GridBits-1:0] GridMax = {GridBits{1'b1}};
  localparam int DiffW = 33;
  localparam int ProdW = DiffW + GridBits;

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_HIL   = 11'b00000010000,
    S_SRD   = 11'b00000100000,
    S_SINS  = 11'b00001000000,
    S_SCMP  = 11'b00010000000,
    S_SPUT  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_ORD   = 11'b10000000000
  } state_t;
endpackage

FILE: hw/rtl/hilbert_spatial_sort_core.sv
`timescale 1ns / 1ps
// Hilbert spatial sort core.
// Input: a point transfers on a clock edge with start high and busy low. Fields are
// longitude (32b signed), latitude (31b signed), is_last. Busy stays low while a set
// loads, so points can transfer every cycle; the node id is the arrival order.
// Points past 64 are dropped and leave the bounding box alone.
// On the point marked is_last the core raises busy and, for a set of n points:
//   - scales every point to a 16-bit grid, floor((c-min)*65535/range), with a
//     restoring divider (one quotient bit per cycle), then forms the 32-bit
//     Hilbert key one curve level per cycle,
//   - insertion-sorts {key, id} entries in the key memory, moving each larger
//     entry up one slot until the inserted entry fits,
//   - emits the ids in order, each read from the key memory and then registered
//     into node_id before it shows with done.
// Results: node_id and last_out are valid only in the cycle done is high; the
// receiver must take the transfer then, it cannot stall. last_out marks the final
// id, and busy drops in that same cycle, so the next set may start right away.
// Reset (rst, synchronous) empties the set and returns to loading; memories are
// not cleared.
module hilbert_spatial_sort_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] longitude,
  input  logic [30:0] latitude,
  input  logic        is_last,
  output logic        done,
  output logic [5:0]  node_id,
  output logic        last_out
);
  hss_pkg::state_t state;
  logic [31:0] lon_mem [hss_pkg::MaxNodes];
  logic [31:0] lat_mem [hss_pkg::MaxNodes];
  logic [hss_pkg::EntW-1:0] key_mem [hss_pkg::MaxNodes];  // {key, id} per sorted slot
  logic [hss_pkg::CntW-1:0] count;
  logic signed [31:0] min_lon, max_lon, min_lat, max_lat;
  logic signed [31:0] lat_in;
  logic [hss_pkg::CntW-1:0] idx, pos;
  logic signed [31:0] lon_rd, lat_rd;
  logic axis;  // 0: x pass, 1: y pass
  logic [hss_pkg::ProdW-1:0] rem;
  logic [hss_pkg::DiffW-1:0] range_q, diff;
  logic [hss_pkg::QuoW-1:0] quo, gx, gy;
  logic [hss_pkg::PosW:0] step;
  logic [hss_pkg::KeyW-1:0] hkey;
  logic [hss_pkg::ProdW+1:0] trial;
  logic [hss_pkg::ProdW-1:0] prod;
  logic qbit;
  logic store_pt;
  logic key_we;
  logic ent_gt;
  logic [hss_pkg::IdW-1:0] key_ra, key_wa;
  logic [hss_pkg::EntW-1:0] key_wd, ent_rd, ent_ins;
  logic [hss_pkg::PosW-1:0] s;
  logic rx, ry;
  logic [hss_pkg::QuoW-1:0] msk, nx, ny;

  assign lat_in = {latitude[30], latitude};
  assign busy = (state != hss_pkg::S_LOAD);
  // Scale by 65535 as (d << 16) - d.
  assign prod = {diff, {hss_pkg::GridBits{1'b0}}} - {{hss_pkg::GridBits{1'b0}}, diff};
  // Shifted remainder against range << 16; a zero range gives a zero grid value.
  assign trial = {1'b0, rem, 1'b0} - {2'b00, range_q, {hss_pkg::GridBits{1'b0}}};
  assign qbit = !trial[hss_pkg::ProdW+1] && (range_q != '0);

  // Store points; memory reads are registered.
  assign store_pt = (state == hss_pkg::S_LOAD) && start
                    && (count < hss_pkg::CntW'(hss_pkg::MaxNodes));
  always_ff @(posedge clk) begin
    if (store_pt) begin
      lon_mem[count[hss_pkg::IdW-1:0]] <= longitude;
      lat_mem[count[hss_pkg::IdW-1:0]] <= lat_in;
    end
    lon_rd <= lon_mem[idx[hss_pkg::IdW-1:0]];
    lat_rd <= lat_mem[idx[hss_pkg::IdW-1:0]];
  end

  // Key memory: one write and one registered read per cycle, never the same entry
  // in a cycle whose read data is used.
  assign ent_gt = ent_rd[hss_pkg::EntW-1:hss_pkg::IdW] > ent_ins[hss_pkg::EntW-1:hss_pkg::IdW];
  assign key_we = (state == hss_pkg::S_HIL && step == '0) || state == hss_pkg::S_SCMP
                  || state == hss_pkg::S_SPUT;
  assign key_wa = (state == hss_pkg::S_HIL) ? idx[hss_pkg::IdW-1:0] : pos[hss_pkg::IdW-1:0];
  assign key_wd = (state == hss_pkg::S_HIL) ? {hkey, idx[hss_pkg::IdW-1:0]} :
                  ((state == hss_pkg::S_SCMP && ent_gt) ? ent_rd : ent_ins);

  always_comb begin
    unique case (state)
      hss_pkg::S_SINS: key_ra = hss_pkg::IdW'(pos - 1'b1);
      hss_pkg::S_SCMP: key_ra = hss_pkg::IdW'(pos - 2'd2);
      default:         key_ra = idx[hss_pkg::IdW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we)
      key_mem[key_wa] <= key_wd;
    ent_rd <= key_mem[key_ra];
  end

  // Hilbert level on (gx, gy) at bit step-1.
  always_comb begin
    s = hss_pkg::PosW'(step - 1'b1);
    rx = gx[s];
    ry = gy[s];
    msk = (hss_pkg::QuoW'(1) << s) - 1'b1;
    nx = gx;
    ny = gy;
    if (!ry) begin
      if (rx) begin
        nx = ~gy & msk;
        ny = ~gx & msk;
      end else begin
        nx = gy;
        ny = gx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hss_pkg::S_LOAD;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == hss_pkg::S_OUT);
      unique case (state)
        hss_pkg::S_LOAD: begin
          if (start) begin
            if (count < hss_pkg::CntW'(hss_pkg::MaxNodes)) begin
              if (count == '0 || $signed(longitude) < min_lon) min_lon <= longitude;
              if (count == '0 || $signed(longitude) > max_lon) max_lon <= longitude;
              if (count == '0 || lat_in < min_lat) min_lat <= lat_in;
              if (count == '0 || lat_in > max_lat) max_lat <= lat_in;
              count <= count + 1'b1;
            end
            if (is_last) begin
              idx <= '0;
              state <= hss_pkg::S_RD;
            end
          end
        end
        hss_pkg::S_RD: begin
          // Read of point idx is in flight; its data lands at the end of this cycle.
          axis <= 1'b0;
          state <= hss_pkg::S_MUL;
        end
        hss_pkg::S_MUL: begin
          if (!axis) begin
            diff <= $signed({lon_rd[31], lon_rd}) - $signed({min_lon[31], min_lon});
            range_q <= $signed({max_lon[31], max_lon}) - $signed({min_lon[31], min_lon});
          end else begin
            diff <= $signed({lat_rd[31], lat_rd}) - $signed({min_lat[31], min_lat});
            range_q <= $signed({max_lat[31], max_lat}) - $signed({min_lat[31], min_lat});
          end
          step <= '0;
          state <= hss_pkg::S_DIV;
        end
        hss_pkg::S_DIV: begin
          // Load product, then one quotient bit per cycle (MSB first).
          if (step == '0) begin
            rem <= prod;
            quo <= '0;
            step <= step + 1'b1;
          end else begin
            rem <= qbit ? trial[hss_pkg::ProdW-1:0] : {rem[hss_pkg::ProdW-2:0], 1'b0};
            quo <= {quo[hss_pkg::QuoW-2:0], qbit};
            if (step == (hss_pkg::PosW+1)'(hss_pkg::GridBits)) begin
              if (!axis) begin
                gx <= {quo[hss_pkg::QuoW-2:0], qbit};
                axis <= 1'b1;
                state <= hss_pkg::S_MUL;
              end else begin
                gy <= {quo[hss_pkg::QuoW-2:0], qbit};
                hkey <= '0;
                step <= (hss_pkg::PosW+1)'(hss_pkg::GridBits);
                state <= hss_pkg::S_HIL;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        hss_pkg::S_HIL: begin
          // One curve level per cycle; at step zero the key is written back.
          if (step != '0) begin
            hkey <= hkey | (hss_pkg::KeyW'({rx, rx ^ ry}) << {s, 1'b0});
            gx <= nx;
            gy <= ny;
            step <= step - 1'b1;
          end else if (idx + 1'b1 == count) begin
            if (count > hss_pkg::CntW'(1)) begin
              idx <= hss_pkg::CntW'(1);
              pos <= hss_pkg::CntW'(1);
              state <= hss_pkg::S_SRD;
            end else begin
              idx <= '0;
              state <= hss_pkg::S_ORD;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= hss_pkg::S_RD;
          end
        end
        // Insertion sort: idx = slot being inserted, pos = hole position.
        hss_pkg::S_SRD: begin
          // Fetch the entry to insert.
          state <= hss_pkg::S_SINS;
        end
        hss_pkg::S_SINS: begin
          // Hold the inserted entry; read the neighbor below the hole.
          ent_ins <= ent_rd;
          state <= hss_pkg::S_SCMP;
        end
        hss_pkg::S_SCMP: begin
          if (ent_gt) begin
            // Move the larger entry up into the hole and read the next one down.
            pos <= pos - 1'b1;
            state <= (pos == hss_pkg::CntW'(1)) ? hss_pkg::S_SPUT : hss_pkg::S_SCMP;
          end else if (idx + 1'b1 == count) begin
            idx <= '0;
            state <= hss_pkg::S_ORD;
          end else begin
            idx <= idx + 1'b1;
            pos <= idx + 1'b1;
            state <= hss_pkg::S_SRD;
          end
        end
        hss_pkg::S_SPUT: begin
          // Drop the inserted entry into slot zero.
          if (idx + 1'b1 == count) begin
            idx <= '0;
            state <= hss_pkg::S_ORD;
          end else begin
            idx <= idx + 1'b1;
            pos <= idx + 1'b1;
            state <= hss_pkg::S_SRD;
          end
        end
        hss_pkg::S_ORD: begin
          // Read slot idx for output.
          state <= hss_pkg::S_OUT;
        end
        hss_pkg::S_OUT: begin
          node_id <= ent_rd[hss_pkg::IdW-1:0];
          last_out <= (idx + 1'b1 == count);
          if (idx + 1'b1 == count) begin
            count <= '0;
            state <= hss_pkg::S_LOAD;
          end else begin
            idx <= idx + 1'b1;
            state <= hss_pkg::S_ORD;
          end
        end
        default: state <= hss_pkg::S_LOAD;
      endcase
    end
  end
endmodule

FILE: hw/rtl/hss_checker.sv
`timescale 1ns / 1ps
module hss_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic is_last,
  input logic done,
  input logic last_out
);
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_last |=> busy) else $error("no busy after last point");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last_out |-> busy) else $error("result outside busy");
  a_lastout_done: assert property (@(posedge clk) disable iff (rst)
    last_out && done |=> !done) else $error("result after last");
endmodule

bind hilbert_spatial_sort_core hss_checker u_hss_checker (.*);
